// File: src/bba_pkg.sv
// bba_pkg: shared types and constants for the buddy block allocator.
// No dependencies; bba_front, bba_back, the top level and the testbench import this package.
package bba_pkg;

  localparam int ADDR_W = 16;   // block address width
  localparam int REQ_W  = 17;   // request byte count width
  localparam int NEED_W = 18;   // request plus header plus rounding
  localparam int ORD_W  = 4;    // command order field, holds up to 15
  localparam int GORD_W = 3;    // granted order port width
  localparam int STAT_W = 2;

  // node codes of the block tree
  localparam logic [1:0] NODE_ABSENT = 2'd0;
  localparam logic [1:0] NODE_FREE   = 2'd1;
  localparam logic [1:0] NODE_USED   = 2'd2;
  localparam logic [1:0] NODE_SPLIT  = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_FREE  = 2'd3;

  // classified command, front to back
  typedef struct packed {
    logic              is_free;
    logic              too_large;
    logic [ORD_W-1:0]  order;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [GORD_W-1:0] order;
    logic [STAT_W-1:0] status;
  } res_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage

// File: src/bba_ram.sv
// bba_ram: generic single-port RAM with registered read.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 255
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/bba_fifo.sv
// bba_fifo: small register queue used between front and back and on the result side.
// No dependencies.
module bba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wdata;
    end
  end

endmodule

// File: src/bba_front.sv
// bba_front: accepts items, sizes allocate requests into a block order, queues commands.
// Depends on bba_pkg and bba_fifo.
module bba_front #(
  parameter int NUM_ORDERS      = 8,
  parameter int MIN_BLOCK_BYTES = 512,
  parameter int HEADER_BYTES    = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           hold,
  input  logic                           push,
  output logic                           full,
  input  logic                           kind,
  input  logic [bba_pkg::REQ_W-1:0]      request_bytes,
  input  logic [bba_pkg::ADDR_W-1:0]     block_address,
  input  logic                           cmd_pop,
  output logic                           cmd_empty,
  output bba_pkg::cmd_t                  cmd
);
  import bba_pkg::*;

  localparam int LOG2_MIN = $clog2(MIN_BLOCK_BYTES);
  localparam int TOP      = NUM_ORDERS - 1;
  localparam int BLK_W    = NEED_W - LOG2_MIN;
  localparam int OBIT_W   = $clog2(BLK_W + 1);

  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] rounded;
  logic [BLK_W-1:0]  blocks;
  logic [BLK_W-1:0]  bm1;
  logic [OBIT_W-1:0] ord;
  logic              q_full;
  cmd_t              cmd_in;

  // bytes plus header, rounded up to whole minimum blocks
  assign need    = NEED_W'(request_bytes) + NEED_W'(HEADER_BYTES);
  assign rounded = need + NEED_W'(MIN_BLOCK_BYTES - 1);
  assign blocks  = rounded[NEED_W-1:LOG2_MIN];
  assign bm1     = (blocks == '0) ? '0 : blocks - BLK_W'(1);

  // order is the bit length of blocks minus one
  always_comb begin
    ord = '0;
    for (int i = 0; i < BLK_W; i++) begin
      if (bm1[i]) begin
        ord = OBIT_W'(i + 1);
      end
    end
  end

  always_comb begin
    cmd_in.is_free   = kind;
    cmd_in.too_large = (ord > OBIT_W'(TOP));
    cmd_in.order     = ORD_W'(ord);
    cmd_in.addr      = block_address;
  end

  assign full = q_full || hold;

  bba_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !hold),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

// File: src/bba_back.sv
// bba_back: sequencer that walks the block tree to allocate, split, free and merge.
// Depends on bba_pkg and bba_ram.
module bba_back #(
  parameter int NUM_ORDERS      = 8,
  parameter int MIN_BLOCK_BYTES = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_empty,
  input  bba_pkg::cmd_t        cmd,
  output logic                 cmd_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output bba_pkg::res_t        res,
  output bba_pkg::back_stat_t  stat
);
  import bba_pkg::*;

  localparam int LOG2_MIN   = $clog2(MIN_BLOCK_BYTES);
  localparam int TOP        = NUM_ORDERS - 1;
  localparam int NODE_COUNT = (1 << NUM_ORDERS) - 1;
  localparam int NW         = $clog2(NODE_COUNT);
  localparam int KW         = NUM_ORDERS - 1;
  localparam int LVL_W      = $clog2(NUM_ORDERS);
  localparam int CW         = NUM_ORDERS;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_A_LVL = 5'd2;
  localparam logic [4:0] S_A_RD  = 5'd3;
  localparam logic [4:0] S_A_CK  = 5'd4;
  localparam logic [4:0] S_A_SP1 = 5'd5;
  localparam logic [4:0] S_A_SP2 = 5'd6;
  localparam logic [4:0] S_A_SP3 = 5'd7;
  localparam logic [4:0] S_A_USE = 5'd8;
  localparam logic [4:0] S_F_RD  = 5'd9;
  localparam logic [4:0] S_F_CK  = 5'd10;
  localparam logic [4:0] S_F_SET = 5'd11;
  localparam logic [4:0] S_M_RD  = 5'd12;
  localparam logic [4:0] S_M_CK  = 5'd13;
  localparam logic [4:0] S_M_W1  = 5'd14;
  localparam logic [4:0] S_M_W2  = 5'd15;
  localparam logic [4:0] S_M_W3  = 5'd16;
  localparam logic [4:0] S_RESP  = 5'd17;

  logic [4:0]        state;
  logic [NW-1:0]     clr_addr;
  cmd_t              cur;
  logic [LVL_W-1:0]  lvl;
  logic [KW-1:0]     k;
  logic [CW-1:0]     free_count [NUM_ORDERS];
  res_t              res_reg;

  logic [NW-1:0]     mem_addr;
  logic              mem_we;
  logic [1:0]        mem_wdata;
  logic [1:0]        mem_rdata;

  logic [LVL_W-1:0]  ord_l;
  logic [LVL_W-1:0]  lvl_dn;
  logic [LVL_W-1:0]  lvl_up;
  logic [KW-1:0]     lvl_last;
  logic [KW-1:0]     k_dn;
  logic [31:0]       a32;
  logic [31:0]       kf;
  logic [5:0]        sh;
  logic              f_hit;

  function automatic logic [NW-1:0] node_of(input logic [LVL_W-1:0] lv,
                                            input logic [KW-1:0] kk);
    node_of = ((NW'(1) << (LVL_W'(TOP) - lv)) - NW'(1)) + NW'(kk);
  endfunction

  assign ord_l    = cur.order[LVL_W-1:0];
  assign lvl_dn   = lvl - LVL_W'(1);
  assign lvl_up   = lvl + LVL_W'(1);
  assign lvl_last = KW'((NW'(1) << (LVL_W'(TOP) - lvl)) - NW'(1));
  assign k_dn     = k << 1;

  // free lookup: block index at this order, aligned and inside the level
  assign a32   = 32'(cur.addr);
  assign sh    = 6'(LOG2_MIN) + 6'(lvl);
  assign kf    = a32 >> sh;
  assign f_hit = ((kf << sh) == a32) && ((kf >> (LVL_W'(TOP) - lvl)) == 32'd0);

  // node memory port
  always_comb begin
    mem_addr  = node_of(lvl, k);
    mem_we    = 1'b0;
    mem_wdata = NODE_ABSENT;
    case (state)
      S_CLEAR: begin
        mem_addr  = clr_addr;
        mem_we    = 1'b1;
        mem_wdata = (clr_addr == '0) ? NODE_FREE : NODE_ABSENT;
      end
      S_A_SP1: begin
        mem_we    = 1'b1;
        mem_wdata = NODE_SPLIT;
      end
      S_A_SP2: begin
        mem_addr  = node_of(lvl_dn, k_dn);
        mem_we    = 1'b1;
        mem_wdata = NODE_FREE;
      end
      S_A_SP3: begin
        mem_addr  = node_of(lvl_dn, k_dn | KW'(1));
        mem_we    = 1'b1;
        mem_wdata = NODE_FREE;
      end
      S_A_USE: begin
        mem_we    = 1'b1;
        mem_wdata = NODE_USED;
      end
      S_F_RD:  mem_addr = node_of(lvl, kf[KW-1:0]);
      S_F_SET: begin
        mem_we    = 1'b1;
        mem_wdata = NODE_FREE;
      end
      S_M_RD:  mem_addr = node_of(lvl, k ^ KW'(1));
      S_M_W1: begin
        mem_we    = 1'b1;
        mem_wdata = NODE_ABSENT;
      end
      S_M_W2: begin
        mem_addr  = node_of(lvl, k ^ KW'(1));
        mem_we    = 1'b1;
        mem_wdata = NODE_ABSENT;
      end
      S_M_W3: begin
        mem_addr  = node_of(lvl_up, k >> 1);
        mem_we    = 1'b1;
        mem_wdata = NODE_FREE;
      end
      default: mem_addr = node_of(lvl, k);
    endcase
  end

  bba_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_nodes (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign cmd_pop       = (state == S_IDLE) && !cmd_empty;
  assign res_push      = (state == S_RESP) && !res_full;
  assign res           = res_reg;
  assign stat.clearing = (state == S_CLEAR);
  assign stat.busy     = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        free_count[i] <= (i == TOP) ? CW'(1) : '0;
      end
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NW'(1);
          if (clr_addr == NW'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!cmd_empty) begin
            cur <= cmd;
            k   <= '0;
            if (cmd.is_free) begin
              lvl   <= '0;
              state <= S_F_RD;
            end else if (cmd.too_large) begin
              res_reg <= '{addr: '0, order: '0, status: STAT_TOO_LARGE};
              state   <= S_RESP;
            end else begin
              lvl   <= cmd.order[LVL_W-1:0];
              state <= S_A_LVL;
            end
          end
        end
        // allocate: find the smallest order with a free block
        S_A_LVL: begin
          k <= '0;
          if (free_count[lvl] != '0) begin
            state <= S_A_RD;
          end else if (lvl == LVL_W'(TOP)) begin
            res_reg <= '{addr: '0, order: GORD_W'(cur.order), status: STAT_NO_SPACE};
            state   <= S_RESP;
          end else begin
            lvl <= lvl_up;
          end
        end
        S_A_RD: state <= S_A_CK;
        S_A_CK: begin
          if (mem_rdata == NODE_FREE) begin
            state <= (lvl == ord_l) ? S_A_USE : S_A_SP1;
          end else if (k == lvl_last) begin
            if (lvl == LVL_W'(TOP)) begin
              res_reg <= '{addr: '0, order: GORD_W'(cur.order), status: STAT_NO_SPACE};
              state   <= S_RESP;
            end else begin
              lvl   <= lvl_up;
              state <= S_A_LVL;
            end
          end else begin
            k     <= k + KW'(1);
            state <= S_A_RD;
          end
        end
        // split, keeping the lower half
        S_A_SP1: state <= S_A_SP2;
        S_A_SP2: state <= S_A_SP3;
        S_A_SP3: begin
          free_count[lvl]    <= free_count[lvl] - CW'(1);
          free_count[lvl_dn] <= free_count[lvl_dn] + CW'(2);
          lvl   <= lvl_dn;
          k     <= k_dn;
          state <= (lvl_dn == ord_l) ? S_A_USE : S_A_SP1;
        end
        S_A_USE: begin
          free_count[lvl] <= free_count[lvl] - CW'(1);
          res_reg.addr    <= ADDR_W'(32'(k) << sh);
          res_reg.order   <= GORD_W'(cur.order);
          res_reg.status  <= STAT_OK;
          state           <= S_RESP;
        end
        // free: find the order at which this address is allocated
        S_F_RD: begin
          k <= kf[KW-1:0];
          if (f_hit) begin
            state <= S_F_CK;
          end else if (lvl == LVL_W'(TOP)) begin
            res_reg <= '{addr: '0, order: '0, status: STAT_BAD_FREE};
            state   <= S_RESP;
          end else begin
            lvl <= lvl_up;
          end
        end
        S_F_CK: begin
          if (mem_rdata == NODE_USED) begin
            state <= S_F_SET;
          end else if (lvl == LVL_W'(TOP)) begin
            res_reg <= '{addr: '0, order: '0, status: STAT_BAD_FREE};
            state   <= S_RESP;
          end else begin
            lvl   <= lvl_up;
            state <= S_F_RD;
          end
        end
        S_F_SET: begin
          free_count[lvl] <= free_count[lvl] + CW'(1);
          res_reg <= '{addr: '0, order: GORD_W'(lvl), status: STAT_OK};
          state   <= (lvl == LVL_W'(TOP)) ? S_RESP : S_M_RD;
        end
        // merge with the buddy while it is free
        S_M_RD: state <= S_M_CK;
        S_M_CK: state <= (mem_rdata == NODE_FREE) ? S_M_W1 : S_RESP;
        S_M_W1: state <= S_M_W2;
        S_M_W2: state <= S_M_W3;
        S_M_W3: begin
          free_count[lvl]    <= free_count[lvl] - CW'(2);
          free_count[lvl_up] <= free_count[lvl_up] + CW'(1);
          lvl   <= lvl_up;
          k     <= k >> 1;
          state <= (lvl_up == LVL_W'(TOP)) ? S_RESP : S_M_RD;
        end
        S_RESP: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a command is taken only when the sequencer is idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == S_IDLE))
    else $error("command taken while busy");

  // marking a block allocated always yields a good result
  a_use_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_USE) |=> (state == S_RESP) && (res_reg.status == STAT_OK))
    else $error("allocation did not report success");

  // only clearing and merging write absent nodes
  a_absent_wr: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_wdata == NODE_ABSENT) |->
      (state == S_CLEAR || state == S_M_W1 || state == S_M_W2))
    else $error("unexpected node removal");

  // a result leaves only after the sequencer finishes an item
  a_push_resp: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (state == S_IDLE))
    else $error("result pushed outside response");

endmodule

// File: src/buddy_block_allocator.sv
// Binary buddy allocator: 2^NUM_ORDERS-1 node tree of MIN_BLOCK_BYTES blocks.
// Depends on bba_pkg, bba_front, bba_back, bba_fifo.
//
// Input channel: push/full. kind 0 allocates request_bytes (plus header), kind 1
// frees the block at block_address. Result channel: empty/pop, one result item
// per input item, in order: granted_address, granted_order, status.
// A two-entry command queue decouples intake from the tree sequencer, and a
// two-entry result queue lets the sequencer finish while results wait.
// Each item is worked through on the single node memory port:
//   allocate: skip empty orders, scan nodes, then split down to the order
//   no space: check each order up to the top; too large: no tree access
//   free:     probe orders upward, then merge step by step with free buddies
//             until a buddy check stops the merge below the top order
// After reset the node memory is cleared, one node per cycle, all
// 2^NUM_ORDERS-1 nodes (255 by default); full stays high meanwhile.
// When the receiver stalls, the result queue fills, the sequencer waits,
// then the command queue fills and full rises; nothing is dropped.
module buddy_block_allocator #(
  parameter int NUM_ORDERS      = 8,
  parameter int MIN_BLOCK_BYTES = 512,
  parameter int HEADER_BYTES    = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           kind,
  input  logic [bba_pkg::REQ_W-1:0]      request_bytes,
  input  logic [bba_pkg::ADDR_W-1:0]     block_address,
  output logic                           empty,
  input  logic                           pop,
  output logic [bba_pkg::ADDR_W-1:0]     granted_address,
  output logic [bba_pkg::GORD_W-1:0]     granted_order,
  output logic [bba_pkg::STAT_W-1:0]     status
);
  import bba_pkg::*;

  cmd_t       cmd;
  logic       cmd_empty;
  logic       cmd_pop;
  logic       res_full;
  logic       res_push;
  res_t       res_in;
  res_t       res_out;
  back_stat_t back_stat;

  bba_front #(
    .NUM_ORDERS      (NUM_ORDERS),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
    .HEADER_BYTES    (HEADER_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .hold          (back_stat.clearing),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .request_bytes (request_bytes),
    .block_address (block_address),
    .cmd_pop       (cmd_pop),
    .cmd_empty     (cmd_empty),
    .cmd           (cmd)
  );

  bba_back #(
    .NUM_ORDERS      (NUM_ORDERS),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .stat      (back_stat)
  );

  // result queue
  bba_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign granted_address = res_out.addr;
  assign granted_order   = res_out.order;
  assign status          = res_out.status;

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for buddy_block_allocator.
// Depends on bba_pkg and the allocator RTL; keeps its own buddy tree model.
module tb;
  import bba_pkg::*;

  localparam int ORDERS    = 8;
  localparam int TOP       = ORDERS - 1;
  localparam int NODES     = (1 << ORDERS) - 1;
  localparam int MIN_BYTES = 512;
  localparam int HDR       = 8;
  localparam int CYCLE_CAP = 400000;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic kind = KIND_ALLOC;
  logic [REQ_W-1:0] request_bytes = '0;
  logic [ADDR_W-1:0] block_address = '0;
  logic pop = 1'b0;
  logic full, empty;
  logic [ADDR_W-1:0] granted_address;
  logic [GORD_W-1:0] granted_order;
  logic [STAT_W-1:0] status;

  buddy_block_allocator dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .request_bytes(request_bytes), .block_address(block_address),
    .empty(empty), .pop(pop), .granted_address(granted_address),
    .granted_order(granted_order), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed row: when has_exp, the typed-in result must also match
  typedef struct {
    logic              k;
    logic [REQ_W-1:0]  bytes;
    logic [ADDR_W-1:0] addr;
    logic              has_exp;
    res_t              exp;
  } row_t;

  // model of the block tree
  logic [1:0] tree [NODES];
  int         free_blocks [ORDERS];
  res_t       pending_results [$];
  logic [ADDR_W-1:0] live_blocks [$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet_pop = 0;

  function automatic int level_base(int o);
    return (1 << (TOP - o)) - 1;
  endfunction

  function automatic void tree_reset();
    foreach (tree[i]) tree[i] = NODE_ABSENT;
    foreach (free_blocks[i]) free_blocks[i] = 0;
    tree[0] = NODE_FREE;
    free_blocks[TOP] = 1;
  endfunction

  // allocation: round up, pick lowest free block, split keeping lower half
  function automatic res_t grant_block(logic [REQ_W-1:0] bytes);
    res_t r;
    longint need;
    int blocks, o, j, n, k;
    need = longint'(bytes) + HDR;
    blocks = int'((need + MIN_BYTES - 1) / MIN_BYTES);
    o = 0;
    while ((1 << o) < blocks) o++;
    r = '0;
    if (o > TOP) begin
      r.status = STAT_TOO_LARGE;
      return r;
    end
    n = -1;
    for (j = o; j <= TOP && n < 0; j++) begin
      for (k = 0; k < (1 << (TOP - j)); k++)
        if (tree[level_base(j) + k] == NODE_FREE) begin
          n = level_base(j) + k;
          break;
        end
      if (n >= 0) break;
    end
    if (n < 0) begin
      r.order = o[GORD_W-1:0];
      r.status = STAT_NO_SPACE;
      return r;
    end
    while (j > o) begin
      tree[n] = NODE_SPLIT;
      free_blocks[j]--;
      tree[2*n+1] = NODE_FREE;
      tree[2*n+2] = NODE_FREE;
      free_blocks[j-1] += 2;
      n = 2*n + 1;
      j--;
    end
    tree[n] = NODE_USED;
    free_blocks[o]--;
    r.addr = ADDR_W'((n - level_base(o)) * (MIN_BYTES << o));
    r.order = o[GORD_W-1:0];
    r.status = STAT_OK;
    return r;
  endfunction

  // release: find the allocated block, then merge with free buddies upward
  function automatic res_t release_block(logic [ADDR_W-1:0] a);
    res_t r;
    int o, n, bs, k, buddy, parent, j;
    r = '0;
    n = -1;
    for (o = 0; o <= TOP; o++) begin
      bs = MIN_BYTES << o;
      if (int'(a) % bs == 0) begin
        k = int'(a) / bs;
        if (k < (1 << (TOP - o)) && tree[level_base(o) + k] == NODE_USED) begin
          n = level_base(o) + k;
          break;
        end
      end
    end
    if (n < 0) begin
      r.status = STAT_BAD_FREE;
      return r;
    end
    tree[n] = NODE_FREE;
    free_blocks[o]++;
    j = o;
    while (n > 0) begin
      buddy = (n % 2 == 1) ? n + 1 : n - 1;
      parent = (n - 1) / 2;
      if (tree[buddy] != NODE_FREE) break;
      tree[n] = NODE_ABSENT;
      tree[buddy] = NODE_ABSENT;
      free_blocks[j] -= 2;
      tree[parent] = NODE_FREE;
      free_blocks[j+1]++;
      n = parent;
      j++;
    end
    r.order = o[GORD_W-1:0];
    r.status = STAT_OK;
    return r;
  endfunction

  // send one item, predict on acceptance; push stays high for a following item
  task automatic send_item(logic k, logic [REQ_W-1:0] b, logic [ADDR_W-1:0] a,
                           bit gaps, bit has_exp, res_t exp);
    res_t r;
    if (gaps) begin
      while ($urandom_range(99) < 9) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push <= 1'b1;
    kind <= k;
    request_bytes <= b;
    block_address <= a;
    @(posedge clk);
    while (full) @(posedge clk);
    r = (k == KIND_FREE) ? release_block(a) : grant_block(b);
    if (has_exp && r != exp) begin
      $error("directed row: predicted %h, typed-in %h", r, exp);
      errors++;
    end
    if (k == KIND_ALLOC && r.status == STAT_OK) live_blocks.push_back(r.addr);
    pending_results.push_back(r);
  endtask

  // result side: random stalls, compare field by field
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          res_t e;
          e = pending_results.pop_front();
          if (granted_address !== e.addr) begin
            $error("granted_address exp %h got %h", e.addr, granted_address);
            errors++;
          end
          if (granted_order !== e.order) begin
            $error("granted_order exp %0d got %0d", e.order, granted_order);
            errors++;
          end
          if (status !== e.status) begin
            $error("status exp %0d got %0d", e.status, status);
            errors++;
          end
        end
      end
      pop <= quiet_pop ? 1'b1 : ($urandom_range(99) >= 9);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic res_t mk(logic [ADDR_W-1:0] a, int o, logic [STAT_W-1:0] s);
    res_t r;
    r.addr = a;
    r.order = o[GORD_W-1:0];
    r.status = s;
    return r;
  endfunction

  row_t rows [$];
  res_t none;

  initial begin
    int i, idx, sel, waited;
    logic [REQ_W-1:0] b;
    logic [ADDR_W-1:0] a;
    none = '0;
    tree_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    rows.push_back('{KIND_FREE, 0, 16'h0000, 1, mk(0, 0, STAT_BAD_FREE)});
    rows.push_back('{KIND_ALLOC, 17'h1FFFF, 0, 1, mk(0, 0, STAT_TOO_LARGE)});
    rows.push_back('{KIND_ALLOC, 65536, 0, 1, mk(0, 0, STAT_TOO_LARGE)});
    rows.push_back('{KIND_ALLOC, 65528, 0, 1, mk(0, 7, STAT_OK)});
    rows.push_back('{KIND_ALLOC, 0, 0, 1, mk(0, 0, STAT_NO_SPACE)});
    rows.push_back('{KIND_FREE, 0, 16'h0000, 1, mk(0, 7, STAT_OK)});
    rows.push_back('{KIND_FREE, 0, 16'h0000, 1, mk(0, 0, STAT_BAD_FREE)});
    rows.push_back('{KIND_ALLOC, 0, 0, 1, mk(0, 0, STAT_OK)});
    rows.push_back('{KIND_ALLOC, 504, 0, 1, mk(512, 0, STAT_OK)});
    rows.push_back('{KIND_ALLOC, 505, 0, 0, none});
    rows.push_back('{KIND_ALLOC, 4000, 0, 0, none});
    rows.push_back('{KIND_FREE, 0, 16'h0201, 1, mk(0, 0, STAT_BAD_FREE)});
    rows.push_back('{KIND_FREE, 0, 16'hFFFF, 1, mk(0, 0, STAT_BAD_FREE)});
    rows.push_back('{KIND_FREE, 0, 16'h0200, 0, none});
    rows.push_back('{KIND_FREE, 0, 16'h0000, 0, none});
    rows.push_back('{KIND_ALLOC, 32760, 0, 0, none});
    rows.push_back('{KIND_ALLOC, 32761, 0, 0, none});
    rows.push_back('{KIND_FREE, 0, 16'h8000, 0, none});
    rows.push_back('{KIND_FREE, 0, 16'h0400, 0, none});
    rows.push_back('{KIND_FREE, 0, 16'h1000, 0, none});
    foreach (rows[r])
      send_item(rows[r].k, rows[r].bytes, rows[r].addr, 1'b0, rows[r].has_exp, rows[r].exp);
    push <= 1'b0;

    // drain so the sender pauses until everything is back
    while (pending_results.size() != 0) @(posedge clk);

    // random: mostly valid alloc/free, small sizes, some noise
    for (i = 0; i < 400; i++) begin
      quiet_pop = (i >= 150 && i < 220);
      sel = $urandom_range(99);
      if (sel < 45) begin
        b = (sel < 3) ? REQ_W'($urandom_range(65536, 131071))
          : (sel < 6) ? REQ_W'($urandom_range(16384, 65536))
          : REQ_W'($urandom_range(0, 3000));
        send_item(KIND_ALLOC, b, ADDR_W'($urandom), i < 150 || i >= 220, 0, none);
      end else if (sel < 88 && live_blocks.size() != 0) begin
        idx = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[idx];
        live_blocks.delete(idx);
        send_item(KIND_FREE, REQ_W'($urandom), a, i < 150 || i >= 220, 0, none);
      end else begin
        a = (sel < 94) ? ADDR_W'($urandom_range(0, 127) * 512) : ADDR_W'($urandom);
        send_item(KIND_FREE, REQ_W'($urandom), a, i < 150 || i >= 220, 0, none);
      end
    end
    quiet_pop = 0;
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < 50) begin
      @(posedge clk);
      waited++;
    end
    if (errors == 0 && pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

// File: buddy_block_allocator.f
src/bba_pkg.sv
src/bba_ram.sv
src/bba_fifo.sv
src/bba_front.sv
src/bba_back.sv
src/buddy_block_allocator.sv
tb/tb.sv
